/* src/packed_to_planar_char_convert_top_assert.svh */
// assertion macros for the checker file
`ifndef PACKED_TO_PLANAR_CHAR_CONVERT_TOP_ASSERT_SVH
`define PACKED_TO_PLANAR_CHAR_CONVERT_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define P2PCC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define P2PCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/p2pcc_pkg.sv */
`default_nettype none
package p2pcc_pkg;

  // width of the modulo unit operand (24-bit sum plus carry)
  localparam int MOD_W = 25;

  // planar buffer geometry
  localparam int PLANAR_AW = 11;
  localparam int PLANAR_DEPTH = 2048;
  localparam logic [PLANAR_AW-1:0] PLANAR_MASK = 11'h7ff;

  // colour depth codes
  localparam logic [1:0] CB_8BPP = 2'd0;
  localparam logic [1:0] CB_4BPP = 2'd1;
  localparam logic [1:0] CB_2BPP = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_COLOR_DEPTH = 2'd0;
  localparam logic [1:0] CFG_CHARS_LOG2 = 2'd1;
  localparam logic [1:0] CFG_SOURCE_BASE = 2'd2;
  localparam logic [1:0] CFG_DEST_BASE = 2'd3;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WMOD,
    S_OMOD,
    S_RMOD,
    S_FETCH,
    S_PLANE,
    S_PREAD,
    S_PDATA
  } state_t;

  typedef struct packed {
    logic start;
    logic [MOD_W-1:0] value;
  } mod_req_t;

  typedef struct packed {
    logic done;
    logic [MOD_W-1:0] rem;
  } mod_rsp_t;

  // code three behaves as 2 bpp
  function automatic logic [1:0] depth_clamp(input logic [1:0] code);
    logic [1:0] r;
    r = (code == CB_8BPP || code == CB_4BPP) ? code : CB_2BPP;
    return r;
  endfunction

  // byte offset mask inside one character
  function automatic logic [5:0] char_mask(input logic [1:0] cb);
    logic [5:0] r;
    case (cb)
      CB_8BPP: r = 6'h3f;
      CB_4BPP: r = 6'h1f;
      default: r = 6'h0f;
    endcase
    return r;
  endfunction

  // gather one bitplane out of a packed row, leftmost pixel in bit 7
  function automatic logic [7:0] plane_byte(input logic [63:0] bits, input logic [2:0] p,
                                            input logic [1:0] cb);
    logic [7:0] r;
    r = '0;
    for (int x = 0; x < 8; x++) begin
      case (cb)
        CB_8BPP: r[7-x] = bits[x*8 + int'(p)];
        CB_4BPP: r[7-x] = bits[x*4 + int'(p[1:0])];
        default: r[7-x] = bits[x*2 + int'(p[0])];
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/p2pcc_ram.sv */
`default_nettype none
module p2pcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/p2pcc_mod.sv */
`default_nettype none
module p2pcc_mod #(
  parameter int DIVISOR = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  p2pcc_pkg::mod_req_t  req,
  output p2pcc_pkg::mod_rsp_t  rsp
);
  import p2pcc_pkg::*;

  // remainder by reciprocal multiplication: the quotient estimate is exact or one short,
  // so one compare and subtract finishes the pass
  localparam longint unsigned RECIP = (longint'(1) << MOD_W) / longint'(DIVISOR);
  localparam int RW = $clog2(RECIP + 1);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [MOD_W-1:0] DIV_V = MOD_W'(DIVISOR);

  logic [MOD_W-1:0] v;
  logic [RW-1:0] q;
  logic [MOD_W-1:0] qd;
  logic [2:0] stage;
  logic done;
  logic [MOD_W+RW-1:0] prod;
  logic [MOD_W-1:0] diff;

  // quotient estimate and uncorrected remainder
  assign prod = (MOD_W+RW)'(v) * (MOD_W+RW)'(RECIP_V);
  assign diff = v - qd;

  // three-stage sequencer, done pulses once the remainder is in place
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done <= 1'b0;
    end else begin
      done <= stage[2];
      stage <= {stage[1:0], req.start};
    end
  end

  // estimate, multiply back, subtract and correct
  always_ff @(posedge clk) begin
    if (req.start) begin
      v <= req.value;
    end else if (stage[2]) begin
      v <= (diff >= DIV_V) ? diff - DIV_V : diff;
    end
    if (stage[0]) q <= prod[MOD_W +: RW];
    if (stage[1]) qd <= MOD_W'(q) * DIV_V;
  end

  assign rsp.done = done;
  assign rsp.rem = v;

endmodule
`default_nettype wire

/* src/packed_to_planar_char_convert_top.sv */
`default_nettype none
// Packed to planar character converter. Write beats (tuser low) store one byte of the packed
// bitmap into the work RAM; read beats (tuser high) return one byte of the converted character
// from the 2 KB planar buffer at dest_base. A read on the first byte of a character (16, 32 or
// 64 bytes for 2, 4 or 8 bpp) first converts that tile: 8 rows of bpp bytes are fetched one byte
// a cycle, transposed into bitplanes and written one plane byte a cycle into the buffer. Write
// addresses and tile bases are reduced modulo BITMAP_RAM_BYTES by one shared modulo unit
// (reciprocal multiply, multiply back, subtract and one correction); row steps and byte
// fetches wrap by a compare and subtract. Conversion speed is bounded by the one-byte RAM
// ports. One item is handled at a time; the result sits in an output register, so the next
// beat is taken while it waits. After reset a clearing pass zeroes the planar buffer, during
// which no beat is accepted.
module packed_to_planar_char_convert_top #(
  parameter int BITMAP_RAM_BYTES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address [23:0], write_byte [31:24]
  input  logic [0:0]  s_axis_tuser,   // cmd [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_byte [7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import p2pcc_pkg::*;

  localparam int AW = $clog2(BITMAP_RAM_BYTES);
  localparam logic [AW:0] RAM_BYTES = (AW+1)'(BITMAP_RAM_BYTES);

  // configuration
  logic [1:0] color_depth;
  logic [2:0] cpl;
  logic [23:0] source_base;
  logic [PLANAR_AW-1:0] dest_base;

  state_t state, state_next;

  logic [PLANAR_AW-1:0] clr_addr;
  logic [5:0] addr_lo;
  logic [7:0] wbyte;
  logic [1:0] cb;
  logic [2:0] row;
  logic [3:0] idx;
  logic rd_pend;
  logic [2:0] rd_idx;
  logic [AW-1:0] rowaddr;
  logic [63:0] bits;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  // input decode
  logic in_acc;
  logic cmd_in;
  logic [23:0] addr_in;
  logic [1:0] cb_in;
  logic aligned_in;
  logic [23:0] offs_in;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cmd_in = s_axis_tuser[0];
  assign addr_in = s_axis_tdata[23:0];
  assign cb_in = depth_clamp(color_depth);
  assign aligned_in = (addr_in[5:0] & char_mask(cb_in)) == 6'd0;
  assign offs_in = addr_in - source_base;

  // tile position from the reduced offset
  logic [AW-1:0] offs_r;
  logic [MOD_W-1:0] tile, ty, tx, t_off;

  always_comb begin
    offs_r = mrsp.rem[AW-1:0];
    tile = MOD_W'(offs_r) >> (3'd6 - {1'b0, cb});
    ty = tile >> cpl;
    tx = tile & ((MOD_W'(1) << cpl) - MOD_W'(1));
    t_off = ((ty << ({1'b0, cpl} + 4'd6)) >> cb) + ((tx << 3) >> cb);
  end

  // modulo unit requests
  always_comb begin
    mreq.start = 1'b0;
    mreq.value = '0;
    if (in_acc && cmd_in == CMD_WRITE) begin
      mreq.start = 1'b1;
      mreq.value = MOD_W'(addr_in);
    end else if (in_acc && aligned_in) begin
      mreq.start = 1'b1;
      mreq.value = MOD_W'(offs_in);
    end else if (state == S_OMOD && mrsp.done) begin
      mreq.start = 1'b1;
      mreq.value = MOD_W'(source_base) + t_off;
    end
  end

  p2pcc_mod #(.DIVISOR(BITMAP_RAM_BYTES)) u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // row geometry
  logic [3:0] bpp;
  logic [10:0] bpl;
  logic [AW:0] fetch_sum, fetch_addr, step_sum, step_addr;

  always_comb begin
    bpp = 4'd8 >> cb;
    bpl = (11'd8 << cpl) >> cb;
    fetch_sum = {1'b0, rowaddr} + (AW+1)'(idx);
    fetch_addr = (fetch_sum >= RAM_BYTES) ? fetch_sum - RAM_BYTES : fetch_sum;
    step_sum = {1'b0, rowaddr} + (AW+1)'(bpl);
    step_addr = (step_sum >= RAM_BYTES) ? step_sum - RAM_BYTES : step_sum;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == PLANAR_MASK) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (cmd_in == CMD_WRITE) state_next = S_WMOD;
          else if (aligned_in) state_next = S_OMOD;
          else state_next = S_PREAD;
        end
      end
      S_WMOD: begin
        if (mrsp.done) state_next = S_IDLE;
      end
      S_OMOD: begin
        if (mrsp.done) state_next = S_RMOD;
      end
      S_RMOD: begin
        if (mrsp.done) state_next = S_FETCH;
      end
      S_FETCH: begin
        if (idx == bpp) state_next = S_PLANE;
      end
      S_PLANE: begin
        if (idx == bpp - 4'd1) state_next = (row == 3'd7) ? S_PREAD : S_FETCH;
      end
      S_PREAD: state_next = S_PDATA;
      S_PDATA: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // memory controls
  logic bm_we, issuing;
  logic [AW-1:0] bm_waddr, bm_raddr;
  logic [7:0] bm_rdata;
  logic pl_we, load_out;
  logic [PLANAR_AW-1:0] pl_waddr, pl_raddr, plane_addr;
  logic [7:0] pl_wdata, pl_rdata;

  always_comb begin
    s_axis_tready = 1'b0;
    bm_we = 1'b0;
    issuing = 1'b0;
    pl_we = 1'b0;
    load_out = 1'b0;
    pl_waddr = plane_addr;
    pl_wdata = plane_byte(bits, idx[2:0], cb);
    unique case (state)
      S_CLEAR: begin
        pl_we = 1'b1;
        pl_waddr = clr_addr;
        pl_wdata = 8'd0;
      end
      S_IDLE: s_axis_tready = 1'b1;
      S_WMOD: bm_we = mrsp.done;
      S_FETCH: issuing = idx < bpp;
      S_PLANE: pl_we = 1'b1;
      S_PDATA: load_out = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  assign bm_waddr = mrsp.rem[AW-1:0];
  assign bm_raddr = fetch_addr[AW-1:0];
  assign plane_addr = dest_base + PLANAR_AW'({row, 1'b0}) + PLANAR_AW'({idx[2:1], 4'b0000})
                      + PLANAR_AW'(idx[0]);
  assign pl_raddr = dest_base + PLANAR_AW'(addr_lo & char_mask(cb));

  p2pcc_ram #(.WIDTH(8), .DEPTH(BITMAP_RAM_BYTES)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (wbyte),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  p2pcc_ram #(.WIDTH(8), .DEPTH(PLANAR_DEPTH)) u_planar (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      rd_pend <= 1'b0;
      m_axis_tvalid <= 1'b0;
      color_depth <= '0;
      cpl <= '0;
      source_base <= '0;
      dest_base <= '0;
    end else begin
      state <= state_next;
      rd_pend <= issuing;
      if (state == S_CLEAR) clr_addr <= clr_addr + PLANAR_AW'(1);
      if (load_out) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLOR_DEPTH: color_depth <= cfg_data[1:0];
          CFG_CHARS_LOG2:  cpl <= cfg_data[2:0];
          CFG_SOURCE_BASE: source_base <= cfg_data;
          CFG_DEST_BASE:   dest_base <= cfg_data[PLANAR_AW-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      wbyte <= s_axis_tdata[31:24];
      addr_lo <= addr_in[5:0];
      cb <= cb_in;
    end
    if (state == S_RMOD && mrsp.done) begin
      rowaddr <= mrsp.rem[AW-1:0];
      row <= 3'd0;
      idx <= 4'd0;
    end
    rd_idx <= idx[2:0];
    if (rd_pend) bits[rd_idx*8 +: 8] <= bm_rdata;
    if (state == S_FETCH) begin
      idx <= (idx == bpp) ? 4'd0 : idx + 4'd1;
    end
    if (state == S_PLANE) begin
      if (idx == bpp - 4'd1) begin
        idx <= 4'd0;
        row <= row + 3'd1;
        rowaddr <= step_addr[AW-1:0];
      end else begin
        idx <= idx + 4'd1;
      end
    end
    if (load_out) m_axis_tdata <= pl_rdata;
  end

endmodule
`default_nettype wire

/* src/p2pcc_checker.sv */
`default_nettype none
`include "packed_to_planar_char_convert_top_assert.svh"
module p2pcc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [0:0] s_axis_tuser,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // one item at a time: no beat right after an accepted beat
  `P2PCC_ASSERT_NEXT(a_no_back_to_back, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat accepted while busy")

  // the clearing pass holds off input straight after reset
  `P2PCC_ASSERT_NOW(a_clear_after_reset, $past(rst), !s_axis_tready, "input ready during clear")

  // a write beat never brings a result with it
  `P2PCC_ASSERT_NEXT(a_write_silent, s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid, !m_axis_tvalid, "result after a write beat")

  // a stalled result stays
  `P2PCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // a stalled result keeps its data
  `P2PCC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

endmodule

bind packed_to_planar_char_convert_top p2pcc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
